// File: design/tsre_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the TCP sender retransmit engine.
// No dependencies; every other file but tsre_unwrap imports this package.
package tsre_pkg;

  localparam int unsigned MaxPayload = 1452;
  localparam int unsigned QueueDepth = 64;
  localparam int unsigned ResultLimit = 48;

  localparam int unsigned PayloadCapInt = (MaxPayload > 2047) ? 2047 : MaxPayload;
  localparam int unsigned QA_W = $clog2(QueueDepth);
  localparam int unsigned QC_W = $clog2(QueueDepth + 1);
  localparam int unsigned RA_W = $clog2(ResultLimit);
  localparam int unsigned RC_W = $clog2(ResultLimit + 1);

  localparam logic [10:0] PAYLOAD_CAP = 11'(PayloadCapInt);
  localparam logic [QC_W-1:0] QUEUE_FULL = QC_W'(QueueDepth);
  localparam logic [RC_W-1:0] RESULT_MAX = RC_W'(ResultLimit);

  localparam logic [2:0] CMD_PUSH  = 3'd0;
  localparam logic [2:0] CMD_FILL  = 3'd1;
  localparam logic [2:0] CMD_ACK   = 3'd2;
  localparam logic [2:0] CMD_TICK  = 3'd3;
  localparam logic [2:0] CMD_EMPTY = 3'd4;

  localparam logic [1:0] REG_ISN     = 2'd0;
  localparam logic [1:0] REG_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_CAP     = 2'd2;

  // outstanding segment descriptor
  typedef struct packed {
    logic [31:0] off;
    logic [10:0] len;
    logic        syn;
    logic        fin;
  } desc_t;

  // one buffered result, status fields added at drain time
  typedef struct packed {
    logic        valid;
    logic [31:0] seq;
    logic [10:0] len;
    logic        syn;
    logic        fin;
    logic        retx;
  } res_t;

endpackage

// File: design/tsre_unwrap.sv
`timescale 1ns / 1ps
// Sequence number unwrap unit: places a 32-bit offset nearest a 64-bit checkpoint.
// Depends on nothing beyond plain logic; shared by the ack and queue-walk steps.
module tsre_unwrap (
  input  logic [31:0] off,
  input  logic [63:0] cp,
  output logic [63:0] base
);
  logic [31:0] cp_lo;
  logic [31:0] cp_hi;
  logic [31:0] up_gap;
  logic [31:0] dn_gap;

  always_comb begin
    cp_lo  = cp[31:0];
    cp_hi  = cp[63:32];
    up_gap = off - cp_lo;
    dn_gap = cp_lo - off;
    base   = {cp_hi, off};
    if ((off > cp_lo) && (up_gap > 32'h8000_0000) && (cp_hi != 32'd0)) begin
      base = {cp_hi - 32'd1, off};
    end else if ((off < cp_lo) && (dn_gap > 32'h8000_0000) && (cp_hi != 32'hFFFF_FFFF)) begin
      base = {cp_hi + 32'd1, off};
    end
  end
endmodule

// File: design/tsre_queue.sv
`timescale 1ns / 1ps
// Outstanding segment descriptor memory: one write port, one registered read port.
// Depends on tsre_pkg for desc_t and the queue depth.
module tsre_queue (
  input  logic                  clk,
  input  logic                  we,
  input  logic [tsre_pkg::QA_W-1:0] waddr,
  input  tsre_pkg::desc_t       wdata,
  input  logic [tsre_pkg::QA_W-1:0] raddr,
  output tsre_pkg::desc_t       rdata
);
  import tsre_pkg::*;

  desc_t mem [QueueDepth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/tsre_result_buf.sv
`timescale 1ns / 1ps
// Result buffer: holds the items of one step until its status is final.
// Depends on tsre_pkg for res_t and the result limit.
module tsre_result_buf (
  input  logic                  clk,
  input  logic                  we,
  input  logic [tsre_pkg::RA_W-1:0] waddr,
  input  tsre_pkg::res_t        wdata,
  input  logic [tsre_pkg::RA_W-1:0] raddr,
  output tsre_pkg::res_t        rdata
);
  import tsre_pkg::*;

  res_t mem [ResultLimit];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/tcp_sender_retransmit_engine_core.sv
`timescale 1ns / 1ps
// TCP sender retransmit engine top level: command sequencer and state registers.
// Depends on tsre_pkg, tsre_unwrap, tsre_queue and tsre_result_buf.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_ready  | cmd byte_count end_input ack_number rx_window
//          |                      | elapsed_ms
//  out     | out_valid / out_ready| segment fields, last_result, flight_bytes, ...
//  cfg     | cfg_valid / cfg_ready| cfg_index cfg_data
//
// One command at a time. Push, empty and unknown commands go straight to the drain;
// tick first updates and checks a running timer; fill sends a SYN, a FIN or data
// segments; ack may stop after its compare, else retires acked segments and runs a
// fill. The drain runs S_FINISH, then S_DRAIN_REQ and S_DRAIN_LOAD per item, plus any
// out_ready stall. in_ready is high only between commands. Synchronous reset clears
// all control state; the descriptor and result memories need no clearing.
module tcp_sender_retransmit_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [15:0] byte_count,
  input  logic        end_input,
  input  logic [31:0] ack_number,
  input  logic [15:0] rx_window,
  input  logic [15:0] elapsed_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        segment_valid,
  output logic [31:0] segment_seqno,
  output logic [10:0] payload_length,
  output logic        syn_flag,
  output logic        fin_flag,
  output logic        is_retransmit,
  output logic        last_result,
  output logic [16:0] flight_bytes,
  output logic [7:0]  retransmit_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import tsre_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_FILL_WAIT, S_FILL_START, S_FILL_FIN, S_FILL_FREE, S_FILL_SEND,
    S_ACK_UNWRAP, S_ACK_CMP, S_ACK_RD, S_ACK_CHK, S_ACK_END_CMP, S_ACK_END,
    S_TICK1, S_TICK2, S_FINISH, S_DRAIN_REQ, S_DRAIN_LOAD, S_DRAIN_WAIT
  } state_t;

  state_t state;

  logic [31:0] cfg_isn;
  logic [15:0] cfg_timeout;
  logic [15:0] cfg_cap;

  logic [63:0] next_abs;
  logic [63:0] acked_abs;
  logic [15:0] window_reg;
  logic [16:0] in_flight;
  logic [15:0] stream_bytes;
  logic        f_syn, f_fin, f_eof, f_timer, f_backoff;
  logic [31:0] timer_elapsed;
  logic [31:0] current_timeout;
  logic [7:0]  retx_counter;
  logic [QA_W-1:0] q_head;
  logic [QC_W-1:0] q_count;

  logic [31:0] ack_in;
  logic [15:0] win_in;
  logic [15:0] ms_in;
  logic [63:0] abs_ack;
  logic [63:0] edge_abs;
  logic [63:0] seg_base;
  logic [16:0] freeb;
  logic        fresh;
  logic [RC_W-1:0] res_n;
  logic [RA_W-1:0] rd_idx;

  desc_t head;
  res_t  rd_res;

  // combinational helpers
  logic        can_send;
  logic        send_en;
  logic [10:0] send_len;
  logic        send_syn;
  logic        send_fin;
  logic [1:0]  send_extra;
  logic [16:0] send_space;
  logic        emit_en;
  res_t        emit_res;
  desc_t       q_wdata;
  logic [31:0] unwrap_off;
  logic [63:0] unwrap_base;
  logic [63:0] edge_diff;
  logic [10:0] fill_len;
  logic [15:0] sb_after;
  logic        fill_fin;
  logic [16:0] head_space;
  logic [32:0] elapsed_sum;
  logic [15:0] room;
  logic [15:0] push_add;
  logic [QA_W-1:0] q_tail;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign can_send  = (q_count < QUEUE_FULL) && (res_n < RESULT_MAX);
  assign q_tail    = q_head + q_count[QA_W-1:0];
  assign head_space = 17'(head.len) + 17'(head.syn) + 17'(head.fin);
  assign unwrap_off = (state == S_ACK_UNWRAP) ? (ack_in - cfg_isn) : head.off;

  tsre_unwrap u_unwrap (
    .off (unwrap_off),
    .cp  (acked_abs),
    .base(unwrap_base)
  );

  always_comb begin
    edge_diff = edge_abs - next_abs;
    fill_len  = (freeb > 17'(PAYLOAD_CAP)) ? PAYLOAD_CAP : freeb[10:0];
    if (16'(fill_len) > stream_bytes) begin
      fill_len = stream_bytes[10:0];
    end
    sb_after = stream_bytes - 16'(fill_len);
    fill_fin = f_eof && (sb_after == 16'd0) && (17'(fill_len) < freeb);
    elapsed_sum = 33'(timer_elapsed) + 33'(ms_in);
    room = (stream_bytes < cfg_cap) ? (cfg_cap - stream_bytes) : 16'd0;
    push_add = (byte_count < room) ? byte_count : room;
  end

  // segment send and result capture selection
  always_comb begin
    send_en  = 1'b0;
    send_len = 11'd0;
    send_syn = 1'b0;
    send_fin = 1'b0;
    emit_en  = 1'b0;
    emit_res = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && (cmd == CMD_EMPTY)) begin
          emit_en  = 1'b1;
          emit_res = '{valid: 1'b1, seq: next_abs[31:0] + cfg_isn, len: 11'd0,
                       syn: 1'b0, fin: 1'b0, retx: 1'b0};
        end
      end
      S_FILL_START: begin
        if (!f_syn && can_send) begin
          send_en  = 1'b1;
          send_syn = 1'b1;
        end
      end
      S_FILL_FIN: begin
        if (f_eof && (stream_bytes == 16'd0) && (edge_abs > next_abs) && can_send) begin
          send_en  = 1'b1;
          send_fin = 1'b1;
        end
      end
      S_FILL_SEND: begin
        send_en  = 1'b1;
        send_len = fill_len;
        send_fin = fill_fin;
      end
      S_TICK2: begin
        if ((timer_elapsed >= current_timeout) && (q_count != '0)) begin
          emit_en  = 1'b1;
          emit_res = '{valid: 1'b1, seq: head.off + cfg_isn, len: head.len,
                       syn: head.syn, fin: head.fin, retx: 1'b1};
        end
      end
      S_FINISH: begin
        if (res_n == '0) begin
          emit_en  = 1'b1;
          emit_res = '0;
        end
      end
      default: begin
      end
    endcase
    if (send_en) begin
      emit_en  = 1'b1;
      emit_res = '{valid: 1'b1, seq: next_abs[31:0] + cfg_isn, len: send_len,
                   syn: send_syn, fin: send_fin, retx: 1'b0};
    end
    send_extra = {1'b0, send_syn} + {1'b0, send_fin};
    send_space = 17'(send_len) + 17'(send_extra);
    q_wdata.off = next_abs[31:0];
    q_wdata.len = send_len;
    q_wdata.syn = send_syn;
    q_wdata.fin = send_fin;
  end

  tsre_queue u_queue (
    .clk  (clk),
    .we   (send_en),
    .waddr(q_tail),
    .wdata(q_wdata),
    .raddr(q_head),
    .rdata(head)
  );

  tsre_result_buf u_rbuf (
    .clk  (clk),
    .we   (emit_en && (res_n < RESULT_MAX)),
    .waddr(res_n[RA_W-1:0]),
    .wdata(emit_res),
    .raddr(rd_idx),
    .rdata(rd_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      cfg_isn         <= 32'd0;
      cfg_timeout     <= 16'd1000;
      cfg_cap         <= 16'hFFFF;
      next_abs        <= 64'd0;
      acked_abs       <= 64'd0;
      window_reg      <= 16'd1;
      in_flight       <= 17'd0;
      stream_bytes    <= 16'd0;
      f_syn           <= 1'b0;
      f_fin           <= 1'b0;
      f_eof           <= 1'b0;
      f_timer         <= 1'b0;
      f_backoff       <= 1'b0;
      timer_elapsed   <= 32'd0;
      current_timeout <= 32'd1000;
      retx_counter    <= 8'd0;
      q_head          <= '0;
      q_count         <= '0;
      res_n           <= '0;
      rd_idx          <= '0;
      fresh           <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_ISN:     cfg_isn     <= cfg_data;
          REG_TIMEOUT: cfg_timeout <= cfg_data[15:0];
          REG_CAP:     cfg_cap     <= cfg_data[15:0];
          default: begin
          end
        endcase
      end

      if (emit_en && (res_n < RESULT_MAX)) begin
        res_n <= res_n + 1'b1;
      end

      if (send_en) begin
        in_flight <= in_flight + send_space;
        next_abs  <= next_abs + 64'(send_space);
        q_count   <= q_count + 1'b1;
        if (!f_timer) begin
          f_timer       <= 1'b1;
          timer_elapsed <= 32'd0;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            res_n  <= '0;
            ack_in <= ack_number;
            win_in <= rx_window;
            ms_in  <= elapsed_ms;
            if (emit_en) begin
              res_n <= RC_W'(1);
            end
            unique case (cmd)
              CMD_PUSH: begin
                if (!f_eof) begin
                  stream_bytes <= stream_bytes + push_add;
                  if (end_input) begin
                    f_eof <= 1'b1;
                  end
                end
                state <= S_FINISH;
              end
              CMD_FILL: state <= S_FILL_WAIT;
              CMD_ACK:  state <= S_ACK_UNWRAP;
              CMD_TICK: state <= S_TICK1;
              default:  state <= S_FINISH;
            endcase
          end
        end
        S_FILL_WAIT: state <= S_FILL_START;
        S_FILL_START: begin
          if (!f_syn) begin
            if (can_send) begin
              f_syn <= 1'b1;
            end
            state <= S_FINISH;
          end else if (((q_count != '0) && head.syn) || f_fin) begin
            state <= S_FINISH;
          end else begin
            if (window_reg == 16'd0) begin
              window_reg <= 16'd1;
              edge_abs   <= acked_abs + 64'd1;
            end else begin
              edge_abs <= acked_abs + 64'(window_reg);
            end
            state <= S_FILL_FIN;
          end
        end
        S_FILL_FIN: begin
          if (f_eof && (stream_bytes == 16'd0)) begin
            if (send_en) begin
              f_fin <= 1'b1;
            end
            state <= S_FINISH;
          end else begin
            state <= S_FILL_FREE;
          end
        end
        S_FILL_FREE: begin
          if (f_fin || (stream_bytes == 16'd0) || !can_send || (edge_abs <= next_abs)) begin
            state <= S_FINISH;
          end else begin
            freeb <= (edge_diff > 64'h1FFFF) ? 17'h1FFFF : edge_diff[16:0];
            state <= S_FILL_SEND;
          end
        end
        S_FILL_SEND: begin
          stream_bytes <= sb_after;
          if (fill_fin) begin
            f_fin <= 1'b1;
          end
          state <= S_FILL_FREE;
        end
        S_ACK_UNWRAP: begin
          abs_ack <= unwrap_base;
          state   <= S_ACK_CMP;
        end
        S_ACK_CMP: begin
          fresh <= 1'b0;
          if (abs_ack > next_abs) begin
            state <= S_FINISH;
          end else begin
            window_reg <= win_in;
            f_backoff  <= (win_in != 16'd0);
            if (abs_ack <= acked_abs) begin
              state <= S_FINISH;
            end else begin
              acked_abs <= abs_ack;
              state     <= S_ACK_RD;
            end
          end
        end
        S_ACK_RD: state <= S_ACK_CHK;
        S_ACK_CHK: begin
          if (q_count == '0) begin
            state <= S_ACK_END;
          end else begin
            seg_base <= unwrap_base;
            state    <= S_ACK_END_CMP;
          end
        end
        S_ACK_END_CMP: begin
          if (abs_ack < (seg_base + 64'(head_space))) begin
            state <= S_ACK_END;
          end else begin
            in_flight <= in_flight - head_space;
            q_head    <= q_head + 1'b1;
            q_count   <= q_count - 1'b1;
            fresh     <= 1'b1;
            state     <= S_ACK_RD;
          end
        end
        S_ACK_END: begin
          if (fresh) begin
            current_timeout <= 32'(cfg_timeout);
            retx_counter    <= 8'd0;
            if (q_count != '0) begin
              timer_elapsed <= 32'd0;
            end
          end
          if (q_count == '0) begin
            f_timer       <= 1'b0;
            timer_elapsed <= 32'd0;
          end
          state <= S_FILL_WAIT;
        end
        S_TICK1: begin
          if (!f_timer) begin
            state <= S_FINISH;
          end else begin
            timer_elapsed <= elapsed_sum[32] ? 32'hFFFF_FFFF : elapsed_sum[31:0];
            state         <= S_TICK2;
          end
        end
        S_TICK2: begin
          if (timer_elapsed >= current_timeout) begin
            timer_elapsed <= 32'd0;
            if (q_count == '0) begin
              f_timer <= 1'b0;
            end else if (f_backoff) begin
              current_timeout <= current_timeout[31] ? 32'hFFFF_FFFF
                                                     : {current_timeout[30:0], 1'b0};
              if (retx_counter != 8'hFF) begin
                retx_counter <= retx_counter + 8'd1;
              end
            end
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          rd_idx <= '0;
          state  <= S_DRAIN_REQ;
        end
        S_DRAIN_REQ: state <= S_DRAIN_LOAD;
        S_DRAIN_LOAD: begin
          segment_valid    <= rd_res.valid;
          segment_seqno    <= rd_res.seq;
          payload_length   <= rd_res.len;
          syn_flag         <= rd_res.syn;
          fin_flag         <= rd_res.fin;
          is_retransmit    <= rd_res.retx;
          last_result      <= (RC_W'(rd_idx) == (res_n - 1'b1));
          flight_bytes     <= in_flight;
          retransmit_count <= retx_counter;
          out_valid        <= 1'b1;
          state            <= S_DRAIN_WAIT;
        end
        S_DRAIN_WAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last_result) begin
              // empty the buffer so the next command writes from slot zero
              res_n <= '0;
              state <= S_IDLE;
            end else begin
              rd_idx <= rd_idx + 1'b1;
              state  <= S_DRAIN_REQ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: bench/tb_tcp_sender_retransmit_engine_core.sv
`timescale 1ns / 1ps
// Self-checking bench for the TCP sender retransmit engine core.
// Depends on tsre_pkg and the design; it predicts every result item from its own sender model.
module tb_tcp_sender_retransmit_engine_core;
  import tsre_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;  // unmapped index, writes are dropped
  localparam logic [63:0] WRAP = 64'h1_0000_0000;

  typedef struct {
    logic [2:0]  cmd;
    logic [15:0] bc;
    logic        eoi;
    logic [31:0] ackn;
    logic [15:0] win;
    logic [15:0] ms;
    bit          rel_ack;  // ack number taken from sender state when offered
  } cmd_item_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] seq;
    logic [10:0] len;
    logic        syn;
    logic        fin;
    logic        retx;
    logic        last;
    logic [16:0] flight;
    logic [7:0]  rcnt;
  } seg_res_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready;
  logic [2:0] cmd = 0;
  logic [15:0] byte_count = 0, rx_window = 0, elapsed_ms = 0;
  logic end_input = 0;
  logic [31:0] ack_number = 0;
  logic out_valid, out_ready = 0;
  logic segment_valid, syn_flag, fin_flag, is_retransmit, last_result;
  logic [31:0] segment_seqno;
  logic [10:0] payload_length;
  logic [16:0] flight_bytes;
  logic [7:0] retransmit_count;
  logic cfg_valid = 0, cfg_ready;
  logic [1:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;

  tcp_sender_retransmit_engine_core dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // sender model state
  logic [31:0] m_isn = 0, m_rto_init = 1000, m_cap = 65535;
  logic [63:0] m_next = 0, m_acked = 0;
  logic [31:0] m_win = 1, m_flight = 0, m_stream = 0;
  bit m_syn, m_fin, m_eof, m_timer, m_backoff;
  logic [31:0] m_elapsed = 0, m_rto = 1000, m_rcnt = 0;
  desc_t m_q[QueueDepth];
  int unsigned m_head = 0, m_count = 0;

  seg_res_t step_res[$];
  seg_res_t seg_expected[$];
  cmd_item_t pending[$];

  int unsigned sent_cnt = 0, acc_cnt = 0;
  int errors = 0;

  function automatic logic [63:0] unwrap(logic [31:0] off, logic [63:0] cp);
    logic [63:0] base;
    base = {cp[63:32], off};
    if (base > cp && base - cp > 64'h8000_0000 && base >= WRAP) base -= WRAP;
    else if (base < cp && cp - base > 64'h8000_0000 && base <= ~64'd0 - WRAP) base += WRAP;
    return base;
  endfunction

  function automatic logic [31:0] space_of(desc_t d);
    return 32'(d.len) + 32'(d.syn) + 32'(d.fin);
  endfunction

  task automatic add_res(bit v, logic [31:0] s, logic [31:0] l, bit sy, bit fi, bit rx);
    seg_res_t r;
    if (step_res.size() >= ResultLimit) return;
    r = '0;
    r.valid = v; r.seq = s; r.len = l[10:0]; r.syn = sy; r.fin = fi; r.retx = rx;
    step_res.push_back(r);
  endtask

  function automatic bit room_to_send();
    return m_count < QueueDepth && step_res.size() < ResultLimit;
  endfunction

  task automatic send_seg(logic [31:0] len, bit sy, bit fi);
    desc_t d;
    d.off = m_next[31:0]; d.len = len[10:0]; d.syn = sy; d.fin = fi;
    m_flight = (m_flight + space_of(d)) & 32'h1FFFF;
    m_next += 64'(space_of(d));
    m_q[(m_head + m_count) % QueueDepth] = d;
    m_count++;
    add_res(1, d.off + m_isn, len, sy, fi, 0);
    if (!m_timer) begin
      m_timer = 1;
      m_elapsed = 0;
    end
  endtask

  task automatic open_window();
    logic [63:0] edge_abs, freeb;
    logic [31:0] len;
    bit fi;
    if (!m_syn) begin
      if (!room_to_send()) return;
      m_syn = 1;
      send_seg(0, 1, 0);
      return;
    end
    if (m_count != 0 && m_q[m_head].syn) return;
    if (m_fin) return;
    if (m_win == 0) m_win = 1;
    edge_abs = m_acked + 64'(m_win);
    if (m_eof && m_stream == 0 && edge_abs > m_next) begin
      if (!room_to_send()) return;
      m_fin = 1;
      send_seg(0, 0, 1);
    end
    while (!m_fin && m_stream != 0 && room_to_send()) begin
      freeb = edge_abs > m_next ? edge_abs - m_next : 0;
      if (freeb == 0) break;
      len = freeb > 64'(PayloadCapInt) ? 32'(PayloadCapInt) : freeb[31:0];
      if (len > m_stream) len = m_stream;
      if (len == 0) break;
      m_stream -= len;
      fi = 0;
      if (m_eof && m_stream == 0 && 64'(len) < freeb) begin
        fi = 1;
        m_fin = 1;
      end
      send_seg(len, 0, fi);
    end
  endtask

  task automatic take_ack(logic [31:0] ackno, logic [31:0] w);
    logic [63:0] abs_ack, seg_end;
    bit fresh;
    fresh = 0;
    abs_ack = unwrap(ackno - m_isn, m_acked);
    if (abs_ack > m_next) return;
    m_win = w;
    m_backoff = w != 0;
    if (abs_ack <= m_acked) return;
    m_acked = abs_ack;
    while (m_count != 0) begin
      seg_end = unwrap(m_q[m_head].off, m_acked) + 64'(space_of(m_q[m_head]));
      if (abs_ack < seg_end) break;
      m_flight = (m_flight - space_of(m_q[m_head])) & 32'h1FFFF;
      m_head = (m_head + 1) % QueueDepth;
      m_count--;
      fresh = 1;
    end
    if (fresh) begin
      m_rto = m_rto_init;
      if (m_count != 0) m_elapsed = 0;
      m_rcnt = 0;
    end
    if (m_count == 0) begin
      m_timer = 0;
      m_elapsed = 0;
    end
    open_window();
  endtask

  task automatic tick(logic [31:0] ms);
    if (!m_timer) return;
    m_elapsed = (m_elapsed > 32'hFFFF_FFFF - ms) ? 32'hFFFF_FFFF : m_elapsed + ms;
    if (m_elapsed < m_rto) return;
    if (m_count == 0) begin
      m_timer = 0;
      m_elapsed = 0;
      return;
    end
    add_res(1, m_q[m_head].off + m_isn, 32'(m_q[m_head].len), m_q[m_head].syn,
            m_q[m_head].fin, 1);
    if (m_backoff) begin
      m_rto = m_rto > 32'h7FFF_FFFF ? 32'hFFFF_FFFF : m_rto * 2;
      if (m_rcnt < 255) m_rcnt++;
    end
    m_elapsed = 0;
  endtask

  task automatic predict_item(cmd_item_t it);
    logic [31:0] room;
    step_res.delete();
    case (it.cmd)
      CMD_PUSH: begin
        if (!m_eof) begin
          room = m_stream < m_cap ? m_cap - m_stream : 0;
          m_stream += (32'(it.bc) < room) ? 32'(it.bc) : room;
          if (it.eoi) m_eof = 1;
        end
      end
      CMD_FILL:  open_window();
      CMD_ACK:   take_ack(it.ackn, 32'(it.win));
      CMD_TICK:  tick(32'(it.ms));
      CMD_EMPTY: add_res(1, m_next[31:0] + m_isn, 0, 0, 0, 0);
      default: ;
    endcase
    if (step_res.size() == 0) add_res(0, 0, 0, 0, 0, 0);
    foreach (step_res[k]) begin
      step_res[k].last = (k == step_res.size() - 1);
      step_res[k].flight = m_flight[16:0];
      step_res[k].rcnt = m_rcnt[7:0];
      seg_expected.push_back(step_res[k]);
    end
  endtask

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // input driver
  int unsigned in_gap = 0;
  always @(negedge clk) begin
    cmd_item_t it;
    if (rst || sent_cnt != acc_cnt) begin
      // hold the offered item
    end else if (in_gap != 0) begin
      in_valid <= 0;
      in_gap--;
    end else if (pending.size() != 0) begin
      it = pending.pop_front();
      if (it.rel_ack) begin
        // pick an ack inside the unacknowledged span, mostly the whole of it
        if ($urandom_range(99) < 60 || m_next == m_acked) it.ackn = m_next[31:0] + m_isn;
        else it.ackn = m_acked[31:0] + m_isn
                       + $urandom_range(32'(m_next - m_acked), 0);
      end
      cmd <= it.cmd; byte_count <= it.bc; end_input <= it.eoi;
      ack_number <= it.ackn; rx_window <= it.win; elapsed_ms <= it.ms;
      in_valid <= 1;
      sent_cnt++;
      in_gap = gap_len();
    end else begin
      in_valid <= 0;
    end
  end

  // receiver readiness, with one long hold-off once traffic is flowing
  int unsigned rdy_gap = 0, hold_cnt = 0;
  bit hold_done = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else if (hold_cnt != 0) begin
      out_ready <= 0;
      hold_cnt--;
    end else if (!hold_done && acc_cnt >= 60) begin
      hold_done = 1;
      hold_cnt = 400;
      out_ready <= 0;
    end else if (rdy_gap != 0) begin
      out_ready <= 0;
      rdy_gap--;
    end else begin
      out_ready <= 1;
      rdy_gap = gap_len();
    end
  end

  // monitor: predict accepted items, check result items
  always @(posedge clk) begin
    seg_res_t got, exp_r;
    cmd_item_t it;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{segment_valid, segment_seqno, payload_length, syn_flag, fin_flag,
                is_retransmit, last_result, flight_bytes, retransmit_count};
        if (seg_expected.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result item %p", got);
        end else begin
          exp_r = seg_expected.pop_front();
          if (got !== exp_r) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p got %p", exp_r, got);
          end
        end
      end
      if (in_valid && in_ready) begin
        it.cmd = cmd; it.bc = byte_count; it.eoi = end_input; it.ackn = ack_number;
        it.win = rx_window; it.ms = elapsed_ms; it.rel_ack = 0;
        predict_item(it);
        acc_cnt++;
      end
    end
  end

  task automatic queue_cmd(logic [2:0] c, logic [15:0] bc, logic eoi, logic [31:0] an,
                           logic [15:0] w, logic [15:0] ms, bit rel);
    cmd_item_t it;
    it.cmd = c; it.bc = bc; it.eoi = eoi; it.ackn = an; it.win = w; it.ms = ms;
    it.rel_ack = rel;
    pending.push_back(it);
  endtask

  task automatic queue_random(int n, bit allow_end);
    int unsigned r;
    logic [15:0] w;
    repeat (n) begin
      r = $urandom_range(99);
      w = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(8000));
      if (r < 20)
        queue_cmd(CMD_PUSH, $urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(4000)),
                  allow_end && $urandom_range(29) == 0, $urandom, 16'($urandom),
                  16'($urandom), 0);
      else if (r < 42)
        queue_cmd(CMD_FILL, 16'($urandom), 0, $urandom, 16'($urandom), 16'($urandom), 0);
      else if (r < 72) queue_cmd(CMD_ACK, 16'($urandom), 0, 0, w, 16'($urandom), 1);
      else if (r < 88)
        queue_cmd(CMD_TICK, 16'($urandom), 0, $urandom, 16'($urandom),
                  $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(1500)), 0);
      else if (r < 93)
        queue_cmd(CMD_EMPTY, 16'($urandom), 0, $urandom, 16'($urandom), 16'($urandom), 0);
      else
        queue_cmd(3'($urandom), 16'($urandom), 1'($urandom), $urandom, 16'($urandom),
                  16'($urandom), 0);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ISN:     m_isn = val;
      REG_TIMEOUT: m_rto_init = {16'd0, val[15:0]};
      REG_CAP:     m_cap = {16'd0, val[15:0]};
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending.size() != 0 || sent_cnt != acc_cnt || seg_expected.size() != 0);
    repeat (30) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    write_reg(REG_ISN, 32'hFFFF_FF00);
    write_reg(REG_TIMEOUT, 1);
    write_reg(REG_CAP, 65535);
    // directed: extremes and corner commands
    queue_cmd(CMD_TICK, 0, 0, 0, 0, 16'hFFFF, 0);
    queue_cmd(CMD_PUSH, 0, 0, 0, 0, 0, 0);
    queue_cmd(CMD_FILL, 0, 0, 0, 0, 0, 0);        // SYN
    queue_cmd(CMD_TICK, 0, 0, 0, 0, 1, 0);        // retransmit SYN before backoff
    queue_cmd(CMD_ACK, 0, 0, 0, 0, 0, 1);         // SYN usually acked, zero window
    queue_cmd(CMD_PUSH, 16'hFFFF, 0, 0, 0, 0, 0);
    queue_cmd(CMD_PUSH, 16'hFFFF, 0, 0, 0, 0, 0); // saturates at capacity
    queue_cmd(CMD_FILL, 0, 0, 0, 0, 0, 0);        // zero window treated as one
    queue_cmd(CMD_ACK, 0, 0, 0, 16'hFFFF, 0, 1);  // large window: full step
    queue_cmd(CMD_ACK, 16'h0000, 0, 32'h7FFF_0000, 16'hFFFF, 0, 0); // beyond next
    queue_cmd(CMD_TICK, 0, 0, 0, 0, 16'hFFFF, 0);
    queue_cmd(CMD_TICK, 0, 0, 0, 0, 16'hFFFF, 0);
    queue_cmd(CMD_ACK, 0, 0, 0, 16'd10, 0, 1);    // window shrunk below sent data
    queue_cmd(CMD_FILL, 0, 0, 0, 0, 0, 0);
    queue_cmd(CMD_EMPTY, 0, 0, 0, 0, 0, 0);
    queue_cmd(3'd5, 16'hFFFF, 1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 0);
    queue_cmd(3'd7, 0, 0, 0, 0, 0, 0);
    queue_random(45, 0);
    drain();

    write_reg(REG_ISN, 0);
    write_reg(REG_TIMEOUT, 65535);
    write_reg(REG_CAP, 1);                        // below held bytes
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    queue_random(50, 0);
    drain();

    write_reg(REG_ISN, $urandom);
    write_reg(REG_TIMEOUT, $urandom_range(3000, 1));
    write_reg(REG_CAP, $urandom_range(65535, 1));
    queue_random(50, 0);
    drain();

    write_reg(REG_ISN, 32'hFFFF_FFFF);
    write_reg(REG_CAP, 65535);
    queue_random(40, 0);
    queue_cmd(CMD_PUSH, 100, 1, 0, 0, 0, 0);      // end of stream
    queue_cmd(CMD_PUSH, 500, 0, 0, 0, 0, 0);      // dropped after end
    queue_cmd(CMD_ACK, 0, 0, 0, 16'hFFFF, 0, 1);
    queue_cmd(CMD_FILL, 0, 0, 0, 0, 0, 0);        // FIN
    queue_random(15, 1);
    drain();

    if (errors == 0 && seg_expected.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: sim.f
design/tsre_pkg.sv
design/tsre_unwrap.sv
design/tsre_queue.sv
design/tsre_result_buf.sv
design/tcp_sender_retransmit_engine_core.sv
bench/tb_tcp_sender_retransmit_engine_core.sv
